FILE: src/nfr_pkg.sv
// nfr_pkg: shared types and constants of the NPI frame receiver.
// Used by nfr_cfg, nfr_parser and npi_frame_receiver; depends on nothing.
package nfr_pkg;

    localparam int BUFFER_BYTES = 128;

    // register indexes on the configuration port
    localparam logic [1:0] REG_START_BYTE  = 2'd0;
    localparam logic [1:0] REG_STORE_LIMIT = 2'd1;
    localparam logic [1:0] REG_HUNT_LIMIT  = 2'd2;

    localparam logic [7:0] START_BYTE_RST  = 8'd254;
    localparam logic [7:0] STORE_LIMIT_RST = 8'd128;
    localparam logic [3:0] HUNT_LIMIT_RST  = 4'd10;

    typedef enum logic [1:0] {
        STAT_BUSY     = 2'd0,
        STAT_OK       = 2'd1,
        STAT_CHECK    = 2'd2,
        STAT_NO_START = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        PH_HUNT    = 3'd0,
        PH_LEN_LO  = 3'd1,
        PH_LEN_HI  = 3'd2,
        PH_CMD0    = 3'd3,
        PH_CMD1    = 3'd4,
        PH_PAYLOAD = 3'd5,
        PH_CHECK   = 3'd6
    } phase_t;

    // configuration as seen by the parser
    typedef struct packed {
        logic [7:0] start_byte;
        logic [7:0] store_limit;
        logic [3:0] hunt_limit;
        logic       hunt_wr;        // hunt_limit written this cycle
        logic [3:0] hunt_wr_value;
    } cfg_t;

    // one result beat
    typedef struct packed {
        logic       write_enable;
        logic [6:0] write_addr;
        logic [7:0] write_data;
        status_t    frame_status;
    } res_t;

endpackage

FILE: src/npi_frame_receiver.sv
// npi_frame_receiver: top level of the NPI serial frame receiver.
// Depends on nfr_pkg, nfr_cfg and nfr_parser.
//
// Usage:
//   in channel  (in_valid/in_ready, rx_byte): one received serial byte per beat.
//   out channel (out_valid/out_ready, write_enable, write_addr, write_data,
//   frame_status): exactly one result beat per input beat, in order.
//   cfg channel (cfg_valid/cfg_ready, cfg_index, cfg_data): register writes,
//   index 0 start_byte, 1 store_limit, 2 hunt_limit; other indexes ignored.
//   cfg_ready is always high; write only while the block is idle.
// Path: a byte accepted on the in port is held in the input register, then
//   passes through the parser logic into the output register.
// Throughput: one byte per cycle while out_ready is high; the phase
//   machine and XOR check are combinational logic between the two registers.
// Reset: registers return to their defaults and the parser hunts for the
//   start byte with the hunt counter loaded to 10; no beats are pending.
// Stall: when out_ready is low the result holds, the input register keeps
//   one byte more, and in_ready drops only once both stages are full.
module npi_frame_receiver (
    input  logic       clk,
    input  logic       rst_n,

    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data,

    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] rx_byte,

    output logic       out_valid,
    input  logic       out_ready,
    output logic       write_enable,
    output logic [6:0] write_addr,
    output logic [7:0] write_data,
    output logic [1:0] frame_status
);

    nfr_pkg::cfg_t cfg;
    nfr_pkg::res_t res;

    // input stage
    logic       in_full_reg;
    logic [7:0] in_byte_reg;

    // result stage
    logic          out_full_reg;
    nfr_pkg::res_t out_res_reg;

    logic advance;   // input-stage byte moves through the parser this cycle

    assign cfg_ready = 1'b1;
    assign advance   = in_full_reg && (!out_full_reg || out_ready);
    assign in_ready  = !in_full_reg || advance;

    nfr_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    nfr_parser u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (advance),
        .rx_byte (in_byte_reg),
        .cfg     (cfg),
        .res     (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_full_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_byte_reg <= rx_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_full_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_full_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_full_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_res_reg <= res;
        end
    end

    assign out_valid    = out_full_reg;
    assign write_enable = out_res_reg.write_enable;
    assign write_addr   = out_res_reg.write_addr;
    assign write_data   = out_res_reg.write_data;
    assign frame_status = out_res_reg.frame_status;

endmodule

FILE: src/nfr_cfg.sv
// nfr_cfg: configuration registers of the NPI frame receiver.
// Depends on nfr_pkg.
module nfr_cfg (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_valid,
    input  logic [1:0]    cfg_index,
    input  logic [7:0]    cfg_data,
    output nfr_pkg::cfg_t cfg
);

    logic [7:0] start_byte_reg;
    logic [7:0] store_limit_reg;
    logic [3:0] hunt_limit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_byte_reg  <= nfr_pkg::START_BYTE_RST;
            store_limit_reg <= nfr_pkg::STORE_LIMIT_RST;
            hunt_limit_reg  <= nfr_pkg::HUNT_LIMIT_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                nfr_pkg::REG_START_BYTE:  start_byte_reg  <= cfg_data;
                nfr_pkg::REG_STORE_LIMIT: store_limit_reg <= cfg_data;
                nfr_pkg::REG_HUNT_LIMIT:  hunt_limit_reg  <= cfg_data[3:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        cfg.start_byte    = start_byte_reg;
        cfg.store_limit   = store_limit_reg;
        cfg.hunt_limit    = hunt_limit_reg;
        cfg.hunt_wr       = cfg_valid && (cfg_index == nfr_pkg::REG_HUNT_LIMIT);
        cfg.hunt_wr_value = cfg_data[3:0];
    end

endmodule

FILE: src/nfr_parser.sv
// nfr_parser: frame phase machine, counters and running XOR check.
// Depends on nfr_pkg; one byte is processed per step.
module nfr_parser (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          step,
    input  logic [7:0]    rx_byte,
    input  nfr_pkg::cfg_t cfg,
    output nfr_pkg::res_t res
);

    nfr_pkg::phase_t phase_reg, phase_next;
    logic [3:0]  hunt_left_reg, hunt_left_next;
    logic [15:0] frame_length_reg, frame_length_next;
    logic [15:0] payload_seen_reg, payload_seen_next;
    logic [7:0]  check_reg, check_next;
    logic [16:0] position_reg, position_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= nfr_pkg::PH_HUNT;
            hunt_left_reg    <= nfr_pkg::HUNT_LIMIT_RST;
            frame_length_reg <= '0;
            payload_seen_reg <= '0;
            check_reg        <= '0;
            position_reg     <= '0;
        end
        else
        begin
            phase_reg        <= phase_next;
            hunt_left_reg    <= hunt_left_next;
            frame_length_reg <= frame_length_next;
            payload_seen_reg <= payload_seen_next;
            check_reg        <= check_next;
            position_reg     <= position_next;
        end
    end

    always_comb
    begin
        logic            frame_byte;
        logic            stored;
        logic [15:0]     seen_inc;
        nfr_pkg::status_t status;

        phase_next        = phase_reg;
        hunt_left_next    = hunt_left_reg;
        frame_length_next = frame_length_reg;
        payload_seen_next = payload_seen_reg;
        check_next        = check_reg;
        position_next     = position_reg;
        frame_byte        = 1'b1;
        status            = nfr_pkg::STAT_BUSY;
        seen_inc          = payload_seen_reg + 16'd1;

        case (phase_reg)
            nfr_pkg::PH_HUNT:
            begin
                hunt_left_next = hunt_left_reg - 4'd1;
                if (hunt_left_next == 4'd0)
                begin
                    frame_byte = 1'b0;
                    status     = nfr_pkg::STAT_NO_START;
                end
                else if (rx_byte == cfg.start_byte)
                begin
                    check_next = '0;
                    phase_next = nfr_pkg::PH_LEN_LO;
                end
                else
                begin
                    frame_byte = 1'b0;
                end
            end
            nfr_pkg::PH_LEN_LO:
            begin
                frame_length_next = {8'd0, rx_byte};
                check_next        = check_reg ^ rx_byte;
                phase_next        = nfr_pkg::PH_LEN_HI;
            end
            nfr_pkg::PH_LEN_HI:
            begin
                frame_length_next = {rx_byte, frame_length_reg[7:0]};
                check_next        = check_reg ^ rx_byte;
                phase_next        = nfr_pkg::PH_CMD0;
            end
            nfr_pkg::PH_CMD0:
            begin
                check_next = check_reg ^ rx_byte;
                phase_next = nfr_pkg::PH_CMD1;
            end
            nfr_pkg::PH_CMD1:
            begin
                check_next        = check_reg ^ rx_byte;
                payload_seen_next = '0;
                phase_next        = (frame_length_reg == 16'd0) ? nfr_pkg::PH_CHECK
                                                                : nfr_pkg::PH_PAYLOAD;
            end
            nfr_pkg::PH_PAYLOAD:
            begin
                check_next        = check_reg ^ rx_byte;
                payload_seen_next = seen_inc;
                if (seen_inc >= frame_length_reg)
                begin
                    phase_next = nfr_pkg::PH_CHECK;
                end
            end
            default:
            begin
                status = (rx_byte == check_reg) ? nfr_pkg::STAT_OK : nfr_pkg::STAT_CHECK;
            end
        endcase

        stored = frame_byte && (position_reg < {9'd0, cfg.store_limit})
                 && (position_reg < 17'(nfr_pkg::BUFFER_BYTES));

        res.write_enable = stored;
        res.write_addr   = stored ? position_reg[6:0] : 7'd0;
        res.write_data   = stored ? rx_byte : 8'd0;
        res.frame_status = status;

        if (status != nfr_pkg::STAT_BUSY)
        begin
            // end of frame or failed hunt: back to hunting
            phase_next        = nfr_pkg::PH_HUNT;
            hunt_left_next    = cfg.hunt_limit;
            frame_length_next = '0;
            payload_seen_next = '0;
            check_next        = '0;
            position_next     = '0;
        end
        else if (frame_byte)
        begin
            position_next = position_reg + 17'd1;
        end

        if (!step)
        begin
            phase_next        = phase_reg;
            hunt_left_next    = hunt_left_reg;
            frame_length_next = frame_length_reg;
            payload_seen_next = payload_seen_reg;
            check_next        = check_reg;
            position_next     = position_reg;
            // register write while hunting reloads the counter
            if (cfg.hunt_wr && phase_reg == nfr_pkg::PH_HUNT)
            begin
                hunt_left_next = cfg.hunt_wr_value;
            end
        end
    end

endmodule
